// ===== design/tsnt_pkg.sv =====
// Package for the time-sorted note table: sizes, status and request codes,
// configuration register indexes and the beat and entry types.
// No dependencies.
`timescale 1ns / 1ps

package tsnt_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int TIME_W  = 31;
	localparam int PITCH_W = 16;
	localparam int INST_W  = 8;
	localparam int LAYER_W = 8;
	localparam int CNTR_W  = 9;
	localparam int POS_W   = 10;
	localparam int ECNT_W  = 11;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MAX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INST_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 2'd3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	typedef struct packed {
		logic                      req_type;
		logic [TIME_W-1:0]         start_time;
		logic [TIME_W-1:0]         duration;
		logic signed [PITCH_W-1:0] pitch;
		logic [INST_W-1:0]         instrument;
		logic [LAYER_W-1:0]        layer;
		logic [POS_W-1:0]          read_index;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [POS_W-1:0]          position;
		logic [ECNT_W-1:0]         entry_count;
		logic [TIME_W-1:0]         out_start_time;
		logic [TIME_W-1:0]         out_duration;
		logic signed [PITCH_W-1:0] out_pitch;
		logic [INST_W-1:0]         out_instrument;
		logic [LAYER_W-1:0]        out_layer;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0]         start_time;
		logic [TIME_W-1:0]         duration;
		logic signed [PITCH_W-1:0] pitch;
		logic [INST_W-1:0]         instrument;
		logic [LAYER_W-1:0]        layer;
	} entry_t;

endpackage

// ===== design/tsnt_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on tsnt_pkg.
`timescale 1ns / 1ps

interface tsnt_req_if import tsnt_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tsnt_rsp_if import tsnt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/time_sorted_note_table.sv =====
// A read passes from request beat through CHECK and RESP to the response register; an insert
// also runs a binary search of about log2 of the count in steps and moves the later entries up.
// Throughput: one request at a time; the single-port note memory sets the pace, one access a cycle.
// Reset (arst_n low): entry count cleared, configuration back to its defaults; the note memory
// keeps whatever it holds, as only entries below the count are ever used. No clearing pass.
// Depends on tsnt_pkg and the channel interfaces in tsnt_if.
`timescale 1ns / 1ps

module time_sorted_note_table import tsnt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tsnt_req_if.sink              req,
	tsnt_rsp_if.source            rsp
);

	// Sequencer states. A request beat is registered in CHECK, where the
	// note is validated or the read issued. Inserts then run an upper-bound
	// binary search, each step a memory read followed by a compare, and move
	// the later entries up one place, each move a read followed by a write.
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CHECK    = 3'd1;
	localparam logic [2:0] S_SRCH_RD  = 3'd2;
	localparam logic [2:0] S_SRCH_CMP = 3'd3;
	localparam logic [2:0] S_SH_RD    = 3'd4;
	localparam logic [2:0] S_SH_WR    = 3'd5;
	localparam logic [2:0] S_INS      = 3'd6;
	localparam logic [2:0] S_RESP     = 3'd7;

	logic [2:0] state_q;
	logic [CNT_W-1:0] count_q;

	// Configuration registers.
	logic signed [PITCH_W-1:0] pitch_min_q;
	logic signed [PITCH_W-1:0] pitch_max_q;
	logic [CNTR_W-1:0] inst_count_q;
	logic [CNTR_W-1:0] layer_count_q;

	// Search window [lo, hi), move pointer and the pending result.
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;
	logic [IDX_W-1:0] k_q;
	logic [1:0] res_status_q;
	logic [POS_W-1:0] res_pos_q;
	logic res_fill_q;

	req_t req_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	// Note memory: one access port in use per cycle, registered read data.
	entry_t mem [CAPACITY];
	entry_t rd_data_q;
	logic mem_rd_en;
	logic mem_wr_en;
	logic [IDX_W-1:0] mem_rd_addr;
	logic [IDX_W-1:0] mem_wr_addr;
	entry_t mem_wr_data;

	logic [IDX_W:0] lh_sum;
	logic [IDX_W-1:0] mid;
	logic le_new;
	logic [IDX_W-1:0] lo_nx;
	logic [IDX_W-1:0] hi_nx;
	logic [TIME_W:0] end_sum;
	logic note_ok;
	logic read_ok;
	logic slot_free;
	logic rsp_load;
	entry_t new_entry;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign rsp_load = (state_q == S_RESP) && slot_free;

	always_comb begin
		// Midpoint and the next window of the binary search: the window moves
		// right past every entry whose start is at or before the new start, so
		// equal starts keep their arrival order.
		lh_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid = lh_sum[IDX_W:1];
		le_new = (rd_data_q.start_time <= req_q.start_time);
		lo_nx = le_new ? IDX_W'(mid + 1'b1) : lo_q;
		hi_nx = le_new ? hi_q : mid;

		// A note must end within 31 bits, last at least one sample and fall
		// within the configured pitch, instrument and layer ranges.
		end_sum = {1'b0, req_q.start_time} + {1'b0, req_q.duration};
		note_ok = !end_sum[TIME_W]
			&& (req_q.duration != '0)
			&& (req_q.pitch >= pitch_min_q)
			&& (req_q.pitch <= pitch_max_q)
			&& ({1'b0, req_q.instrument} < inst_count_q)
			&& ({1'b0, req_q.layer} < layer_count_q);
		read_ok = ({1'b0, req_q.read_index} < count_q);

		new_entry.start_time = req_q.start_time;
		new_entry.duration = req_q.duration;
		new_entry.pitch = req_q.pitch;
		new_entry.instrument = req_q.instrument;
		new_entry.layer = req_q.layer;
	end

	always_comb begin
		mem_rd_en = 1'b0;
		mem_wr_en = 1'b0;
		mem_rd_addr = mid;
		mem_wr_addr = k_q;
		mem_wr_data = rd_data_q;
		unique case (state_q)
			S_CHECK: begin
				mem_rd_en = (req_q.req_type == REQ_READ);
				mem_rd_addr = req_q.read_index;
			end
			S_SRCH_RD: begin
				mem_rd_en = 1'b1;
			end
			S_SH_RD: begin
				mem_rd_en = 1'b1;
				mem_rd_addr = IDX_W'(k_q - 1'b1);
			end
			S_SH_WR: begin
				mem_wr_en = 1'b1;
			end
			S_INS: begin
				mem_wr_en = 1'b1;
				mem_wr_addr = lo_q;
				mem_wr_data = new_entry;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr_en) begin
			mem[mem_wr_addr] <= mem_wr_data;
		end
		if (mem_rd_en) begin
			rd_data_q <= mem[mem_rd_addr];
		end
	end

	// Control, configuration and sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
			pitch_min_q <= 16'sh8000;
			pitch_max_q <= 16'sh7FFF;
			inst_count_q <= CNTR_W'(256);
			layer_count_q <= CNTR_W'(256);
			lo_q <= '0;
			hi_q <= '0;
			k_q <= '0;
			res_status_q <= ST_OK;
			res_pos_q <= '0;
			res_fill_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PITCH_MIN: pitch_min_q <= cfg_data;
					CFG_PITCH_MAX: pitch_max_q <= cfg_data;
					CFG_INST_COUNT: inst_count_q <= cfg_data[CNTR_W-1:0];
					CFG_LAYER_COUNT: layer_count_q <= cfg_data[CNTR_W-1:0];
					default: begin
					end
				endcase
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (req_q.req_type == REQ_READ) begin
						res_status_q <= read_ok ? ST_OK : ST_RANGE;
						res_pos_q <= req_q.read_index;
						res_fill_q <= read_ok;
						state_q <= S_RESP;
					end else if (!note_ok) begin
						res_status_q <= ST_INVALID;
						res_pos_q <= '0;
						res_fill_q <= 1'b0;
						state_q <= S_RESP;
					end else if (count_q == CNT_W'(CAPACITY)) begin
						res_status_q <= ST_FULL;
						res_pos_q <= '0;
						res_fill_q <= 1'b0;
						state_q <= S_RESP;
					end else begin
						res_fill_q <= 1'b0;
						lo_q <= '0;
						hi_q <= count_q[IDX_W-1:0];
						k_q <= count_q[IDX_W-1:0];
						state_q <= (count_q == '0) ? S_INS : S_SRCH_RD;
					end
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					lo_q <= lo_nx;
					hi_q <= hi_nx;
					if (lo_nx == hi_nx) begin
						state_q <= (k_q == lo_nx) ? S_INS : S_SH_RD;
					end else begin
						state_q <= S_SRCH_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					k_q <= IDX_W'(k_q - 1'b1);
					state_q <= (IDX_W'(k_q - 1'b1) == lo_q) ? S_INS : S_SH_RD;
				end
				S_INS: begin
					count_q <= CNT_W'(count_q + 1'b1);
					res_status_q <= ST_OK;
					res_pos_q <= lo_q;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request and response payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.payload;
		end
		if (rsp_load) begin
			rsp_q.status <= res_status_q;
			rsp_q.position <= res_pos_q;
			rsp_q.entry_count <= count_q;
			if (res_fill_q) begin
				rsp_q.out_start_time <= rd_data_q.start_time;
				rsp_q.out_duration <= rd_data_q.duration;
				rsp_q.out_pitch <= rd_data_q.pitch;
				rsp_q.out_instrument <= rd_data_q.instrument;
				rsp_q.out_layer <= rd_data_q.layer;
			end else begin
				rsp_q.out_start_time <= '0;
				rsp_q.out_duration <= '0;
				rsp_q.out_pitch <= '0;
				rsp_q.out_instrument <= '0;
				rsp_q.out_layer <= '0;
			end
		end
	end

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// Entries are only moved above the insertion point.
	a_move_above: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SH_WR) |-> (k_q > lo_q))
		else $error("entry moved at or below insertion point");

	// The count does not change except when a note is placed.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_INS) |=> (count_q == $past(count_q)))
		else $error("entry count changed outside insertion");

	// A response beat is only raised out of the response state.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("response raised outside response state");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the time-sorted note table: directed and random request beats,
// an in-bench model of the sorted table, and a field-by-field check of every response beat.
// Depends on tsnt_pkg, the channel interfaces in tsnt_if and the time_sorted_note_table RTL.
`timescale 1ns / 1ps

module tb_top;
	import tsnt_pkg::*;

	localparam logic [TIME_W-1:0] TIME_TOP = 31'h7FFF_FFFF;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tsnt_req_if req_ch ();
	tsnt_rsp_if rsp_ch ();

	time_sorted_note_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// Our own copy of the table and of the limit registers. Only entries below
	// note_cnt are meaningful, exactly as in the block.
	entry_t                    note_tbl [CAPACITY];
	int                        note_cnt;
	logic signed [PITCH_W-1:0] lim_pitch_lo;
	logic signed [PITCH_W-1:0] lim_pitch_hi;
	logic [CNTR_W-1:0]         lim_inst;
	logic [CNTR_W-1:0]         lim_layer;

	// Request beats waiting to go out, and the responses we still owe a check.
	req_t request_backlog [$];
	rsp_t awaited_replies [$];
	int   requests_queued;
	int   requests_accepted;

	// Percentage of cycles in which the sender holds valid low and the
	// receiver holds ready low.
	int src_idle;
	int snk_idle;

	int fault_cnt;
	int settings_used;
	int placed_notes;
	int bad_notes;
	int refused_full;
	int reads_done;
	int reads_beyond;

	always #5 clk = ~clk;

	// Works out the response to one accepted request and updates the table
	// copy. Placement is the upper bound: a new note goes after every stored
	// note with the same or an earlier start time, so equal start times keep
	// their arrival order.
	function automatic rsp_t place_or_fetch(req_t r);
		rsp_t              o;
		int                slot;
		int                k;
		logic [TIME_W:0]   end_time;
		logic              fits;
		o = '0;
		if (r.req_type == REQ_INSERT) begin
			// One spare bit catches a start plus duration beyond 31 bits.
			end_time = {1'b0, r.start_time} + {1'b0, r.duration};
			fits = (r.duration != '0) && !end_time[TIME_W]
				&& ($signed(r.pitch) >= lim_pitch_lo) && ($signed(r.pitch) <= lim_pitch_hi)
				&& ({1'b0, r.instrument} < lim_inst) && ({1'b0, r.layer} < lim_layer);
			if (!fits) begin
				// A bad note is reported as such even when there is no room.
				o.status = ST_INVALID;
				bad_notes++;
			end else if (note_cnt >= CAPACITY) begin
				o.status = ST_FULL;
				refused_full++;
			end else begin
				slot = 0;
				while (slot < note_cnt && note_tbl[slot].start_time <= r.start_time)
					slot++;
				for (k = note_cnt; k > slot; k--)
					note_tbl[k] = note_tbl[k - 1];
				note_tbl[slot].start_time = r.start_time;
				note_tbl[slot].duration   = r.duration;
				note_tbl[slot].pitch      = r.pitch;
				note_tbl[slot].instrument = r.instrument;
				note_tbl[slot].layer      = r.layer;
				note_cnt++;
				o.status   = ST_OK;
				o.position = POS_W'(slot);
				placed_notes++;
			end
		end else begin
			o.position = r.read_index;
			reads_done++;
			if (int'(r.read_index) >= note_cnt) begin
				o.status = ST_RANGE;
				reads_beyond++;
			end else begin
				o.status         = ST_OK;
				o.out_start_time = note_tbl[r.read_index].start_time;
				o.out_duration   = note_tbl[r.read_index].duration;
				o.out_pitch      = note_tbl[r.read_index].pitch;
				o.out_instrument = note_tbl[r.read_index].instrument;
				o.out_layer      = note_tbl[r.read_index].layer;
			end
		end
		o.entry_count = ECNT_W'(note_cnt);
		return o;
	endfunction

	// Every field filled with random bits, so that fields a request ignores
	// still toggle.
	function automatic req_t random_request();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	// Where the current limits admit any note: a note that passes every check under
	// them, or, when well_formed is clear, one that breaks exactly one rule.
	function automatic req_t make_note(bit well_formed);
		req_t        r;
		int          lo_p;
		int          hi_p;
		int          top_sel;
		int unsigned room;
		r = random_request();
		r.req_type = REQ_INSERT;
		// Start times cluster at the low end, repeat stored ones, sit near the
		// top of the range, or are fully random.
		case ($urandom_range(0, 4))
			0: r.start_time = TIME_W'($urandom_range(0, 1000));
			1: begin
				if (note_cnt > 0)
					r.start_time = note_tbl[$urandom_range(0, note_cnt - 1)].start_time;
			end
			2: r.start_time = TIME_TOP - TIME_W'($urandom_range(1, 1000));
			default: ;
		endcase
		if (r.start_time == TIME_TOP)
			r.start_time = TIME_TOP - 1;
		room = TIME_TOP - r.start_time;
		case ($urandom_range(0, 7))
			0: r.duration = 1;
			1: r.duration = TIME_W'(room);
			default: r.duration = TIME_W'($urandom_range(1, room < 100000 ? room : 100000));
		endcase

		lo_p = lim_pitch_lo;
		hi_p = lim_pitch_hi;
		if (lo_p <= hi_p) begin
			case ($urandom_range(0, 7))
				0: r.pitch = PITCH_W'(lo_p);
				1: r.pitch = PITCH_W'(hi_p);
				default: r.pitch = PITCH_W'(lo_p + int'($urandom_range(0, hi_p - lo_p)));
			endcase
		end
		if (lim_inst != '0) begin
			top_sel = (lim_inst > 256) ? 255 : int'(lim_inst) - 1;
			r.instrument = INST_W'($urandom_range(0, top_sel));
		end
		if (lim_layer != '0) begin
			top_sel = (lim_layer > 256) ? 255 : int'(lim_layer) - 1;
			r.layer = LAYER_W'($urandom_range(0, top_sel));
		end

		if (!well_formed) begin
			case ($urandom_range(0, 4))
				0: r.duration = '0;
				1: begin
					// Start plus duration lands past the 31-bit range.
					if (r.start_time == '0)
						r.start_time = 1;
					r.duration = (TIME_TOP - r.start_time)
						+ TIME_W'($urandom_range(1, r.start_time));
				end
				2: begin
					if (lo_p > -32768)
						r.pitch = PITCH_W'(lo_p - 1 - int'($urandom_range(0, lo_p + 32767)));
					else if (hi_p < 32767)
						r.pitch = PITCH_W'(hi_p + 1 + int'($urandom_range(0, 32766 - hi_p)));
					else
						r.duration = '0;
				end
				3: begin
					if (lim_inst <= 255)
						r.instrument = INST_W'($urandom_range(lim_inst, 255));
					else
						r.duration = '0;
				end
				default: begin
					if (lim_layer <= 255)
						r.layer = LAYER_W'($urandom_range(lim_layer, 255));
					else
						r.duration = '0;
				end
			endcase
		end
		return r;
	endfunction

	// Reads mostly land on stored entries; the rest are random and so mostly
	// beyond the count while the table is small.
	function automatic req_t make_read();
		req_t r;
		r = random_request();
		r.req_type = REQ_READ;
		if (note_cnt > 0 && $urandom_range(0, 4) != 0)
			r.read_index = POS_W'($urandom_range(0, note_cnt - 1));
		return r;
	endfunction

	function automatic req_t fixed_note(logic [TIME_W-1:0] st, logic [TIME_W-1:0] du,
			int p, int ins, int lay);
		req_t r;
		r = random_request();
		r.req_type   = REQ_INSERT;
		r.start_time = st;
		r.duration   = du;
		r.pitch      = PITCH_W'(p);
		r.instrument = INST_W'(ins);
		r.layer      = LAYER_W'(lay);
		return r;
	endfunction

	function automatic req_t fixed_read(int idx);
		req_t r;
		r = random_request();
		r.req_type   = REQ_READ;
		r.read_index = POS_W'(idx);
		return r;
	endfunction

	// The generator keeps only a short backlog, so that what it builds from
	// the table copy is never far behind the block. It works on the falling
	// edge to stay clear of the driver.
	task automatic queue_request(req_t r);
		while (request_backlog.size() >= 4)
			@(negedge clk);
		request_backlog.push_back(r);
		requests_queued++;
	endtask

	task automatic wait_until_settled();
		while (requests_accepted != requests_queued || awaited_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_PITCH_MIN:   lim_pitch_lo = val;
			CFG_PITCH_MAX:   lim_pitch_hi = val;
			CFG_INST_COUNT:  lim_inst     = val[CNTR_W-1:0];
			CFG_LAYER_COUNT: lim_layer    = val[CNTR_W-1:0];
		endcase
	endtask

	// Limits only change with the block idle: every beat sent has been
	// answered before the first write goes in.
	task automatic set_limits(int lo, int hi, int inst, int lay);
		wait_until_settled();
		write_reg(CFG_PITCH_MIN, CFG_DATA_W'(lo));
		write_reg(CFG_PITCH_MAX, CFG_DATA_W'(hi));
		write_reg(CFG_INST_COUNT, CFG_DATA_W'(inst));
		write_reg(CFG_LAYER_COUNT, CFG_DATA_W'(lay));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_used++;
	endtask

	task automatic random_limits();
		int a;
		int b;
		int t;
		a = int'($urandom_range(0, 65535)) - 32768;
		b = int'($urandom_range(0, 65535)) - 32768;
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		// Now and then a narrow pitch window, so that both edges get hit often.
		if ($urandom_range(0, 1) == 0)
			b = (a + 40 > 32767) ? 32767 : a + int'($urandom_range(0, 40));
		set_limits(a, b, $urandom_range(1, 256), $urandom_range(1, 256));
	endtask

	task automatic run_mix(int count, int insert_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < insert_pct)
				queue_request(make_note($urandom_range(0, 99) < 80));
			else
				queue_request(make_read());
		end
	endtask

	// Driver: a beat is accepted at an edge with valid and ready both high;
	// the expected response is worked out right there, in acceptance order.
	// Valid only drops once the beat on the bus has gone.
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			awaited_replies.push_back(place_or_fetch(req_ch.payload));
			requests_accepted++;
		end
		if (!req_ch.valid || req_ch.ready) begin
			if (arst_n && request_backlog.size() > 0 && $urandom_range(0, 99) >= src_idle) begin
				req_ch.valid   <= 1'b1;
				req_ch.payload <= request_backlog.pop_front();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fault_cnt++;
			if (fault_cnt <= 200)
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
		end
	endtask

	// Monitor: each response beat is held against the oldest expectation.
	// Ready is dropped at random to stall the block's output.
	always @(posedge clk) begin
		rsp_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_replies.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= 200)
					$display("%0t: response beat with nothing outstanding, expected none, actual 0x%0h",
						$time, rsp_ch.payload);
			end else begin
				want = awaited_replies.pop_front();
				check_field("status", want.status, rsp_ch.payload.status);
				check_field("position", want.position, rsp_ch.payload.position);
				check_field("entry_count", want.entry_count, rsp_ch.payload.entry_count);
				check_field("out_start_time", want.out_start_time, rsp_ch.payload.out_start_time);
				check_field("out_duration", want.out_duration, rsp_ch.payload.out_duration);
				check_field("out_pitch", want.out_pitch, rsp_ch.payload.out_pitch);
				check_field("out_instrument", want.out_instrument, rsp_ch.payload.out_instrument);
				check_field("out_layer", want.out_layer, rsp_ch.payload.out_layer);
			end
		end
		rsp_ch.ready <= arst_n && ($urandom_range(0, 99) >= snk_idle);
	end

	// The worst correct run moves about a thousand entries per insert for
	// every request; this bound sits well above that.
	initial begin
		#200_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		req_t             r;
		logic [TIME_W-1:0] fill_time;
		int               fill_left;
		int               step;
		int               one_pitch;

		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		req_ch.valid    = 1'b0;
		req_ch.payload  = '0;
		rsp_ch.ready    = 1'b0;
		src_idle        = 24;
		snk_idle        = 24;
		note_cnt        = 0;
		lim_pitch_lo    = 16'sh8000;
		lim_pitch_hi    = 16'sh7FFF;
		lim_inst        = 9'd256;
		lim_layer       = 9'd256;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset limits: a read of the empty table,
		// the extreme legal notes, equal start times, the overflow and zero
		// duration rejects, and a sweep of reads that ends past the count.
		queue_request(fixed_read(0));
		queue_request(fixed_note(1000, 1, -32768, 0, 0));
		queue_request(fixed_note(TIME_TOP - 1, 1, 32767, 255, 255));
		queue_request(fixed_note(0, TIME_TOP, 0, 128, 1));
		queue_request(fixed_note(1000, 5, -1, 17, 200));
		queue_request(fixed_note(1000, 7, 1, 34, 100));
		queue_request(fixed_note(500, 0, 0, 0, 0));
		queue_request(fixed_note(TIME_TOP, 1, 0, 0, 0));
		queue_request(fixed_note(31'h4000_0000, 31'h4000_0000, 0, 0, 0));
		queue_request(fixed_note(TIME_TOP, TIME_TOP, 0, 0, 0));
		for (int i = 0; i <= 5; i++)
			queue_request(fixed_read(i));
		queue_request(fixed_read(1023));

		// Tight limits: pitch on and just off both edges, the last legal
		// instrument, and the first illegal instrument and layer.
		set_limits(-5, 5, 3, 1);
		queue_request(fixed_note(2000, 10, -5, 2, 0));
		queue_request(fixed_note(2000, 10, 5, 0, 0));
		queue_request(fixed_note(2000, 10, -6, 0, 0));
		queue_request(fixed_note(2000, 10, 6, 0, 0));
		queue_request(fixed_note(2000, 10, 0, 3, 0));
		queue_request(fixed_note(2000, 10, 0, 0, 1));

		// Random part. Mostly legal notes with random content, a share of
		// broken ones, and reads in between.
		random_limits();
		run_mix(50, 65);
		// Hold the sender until the block has answered everything.
		wait_until_settled();
		run_mix(30, 65);

		// Widest limits, and a long stretch with no gaps on either side.
		set_limits(-32768, 32767, 256, 256);
		src_idle = 0;
		snk_idle = 0;
		run_mix(90, 65);

		// Crossed pitch limits and zero counts: nothing can be stored.
		set_limits(32767, -32768, 0, 0);
		src_idle = 24;
		snk_idle = 24;
		run_mix(20, 70);

		// A single legal pitch, instrument and layer.
		one_pitch = int'($urandom_range(0, 65535)) - 32768;
		set_limits(one_pitch, one_pitch, 1, 1);
		run_mix(50, 65);

		// Count registers above the 8-bit index range let every index through.
		set_limits(-32768, 0, 511, 300);
		run_mix(50, 65);

		random_limits();
		run_mix(60, 65);

		// Fill the table. Each new note starts no earlier than the last
		// stored one, so it is appended and the block moves nothing; near
		// the top of the range this gives long runs of equal start times.
		set_limits(-32768, 32767, 256, 256);
		fill_time = (note_cnt > 0) ? note_tbl[note_cnt - 1].start_time : '0;
		fill_left = CAPACITY - note_cnt;
		while (fill_left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_request(make_read());
			end else begin
				r = make_note(1'b1);
				step = $urandom_range(0, 4);
				if (int'(TIME_TOP - 1 - fill_time) < step)
					fill_time = TIME_TOP - 1;
				else
					fill_time = fill_time + TIME_W'(step);
				r.start_time = fill_time;
				r.duration   = TIME_W'($urandom_range(1, TIME_TOP - fill_time));
				queue_request(r);
				fill_left--;
			end
		end

		// Full table: the last slot reads back, a legal note is refused for
		// lack of room, and a bad note is still reported as bad.
		wait_until_settled();
		queue_request(fixed_read(CAPACITY - 1));
		queue_request(fixed_read(0));
		queue_request(fixed_note(3000, 10, 0, 0, 0));
		queue_request(fixed_note(3000, 0, 0, 0, 0));
		random_limits();
		run_mix(120, 50);

		wait_until_settled();
		// A stray response beat would still be caught while the bench waits here.
		repeat (20) @(posedge clk);

		$display("Run covered %0d requests under %0d limit settings: %0d notes placed, %0d bad, %0d refused as full.",
			requests_accepted, settings_used, placed_notes, bad_notes, refused_full);
		$display("Reads: %0d, of which %0d past the stored count; table ended with %0d of %0d entries.",
			reads_done, reads_beyond, note_cnt, CAPACITY);
		if (fault_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
design/tsnt_pkg.sv
design/tsnt_if.sv
design/time_sorted_note_table.sv
tb/tb_top.sv
